>>> design/complex_arithmetic_unit_assert.svh
// assertion macros used by the complex arithmetic unit checker
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CAU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cau assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cau assertion failed");

`endif

>>> design/cau_pkg.sv
// types, constants and helper functions of the complex arithmetic unit
`default_nettype none

package cau_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRAC_BITS     = 16;
    localparam int FIELD_W       = 32;
    localparam int KIND_W        = 3;
    localparam int PROD_W        = 2 * DATA_WIDTH;
    localparam int STEPS_PER_STG = 2;
    localparam int N_ITER_STG    = DATA_WIDTH / STEPS_PER_STG;
    localparam int SQ_REM_W      = DATA_WIDTH + 2;

    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MOD  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CONJ = 3'd5;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [DATA_WIDTH:0]   wide_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [PROD_W:0]       psum_t;
    typedef logic        [PROD_W-1:0]     mag_t;
    typedef logic        [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        logic  sat;
        data_t val;
    } clamp_t;

    typedef struct packed {
        logic                v;
        logic [KIND_W-1:0]   kind;
        data_t               fin_re;
        data_t               fin_im;
        logic                fin_sat;
        logic                fin_dz;
        logic                re_neg;
        logic                re_ovf;
        logic                im_neg;
        logic                im_ovf;
        mag_t                dsr;
        mag_t                re_rem;
        word_t               re_low;
        word_t               re_q;
        mag_t                im_rem;
        word_t               im_low;
        word_t               im_q;
        mag_t                sq_s;
        logic [SQ_REM_W-1:0] sq_rem;
        word_t               sq_root;
    } iter_t;

    // clamp a sign-magnitude value to the signed data range
    function automatic clamp_t clamp_mag(input logic neg, input mag_t mag);
        clamp_t r;
        mag_t   pos_lim;
        pos_lim = mag_t'({(DATA_WIDTH-1){1'b1}});
        r.sat = 1'b0;
        if (!neg)
        begin
            if (mag > pos_lim)
            begin
                r.sat = 1'b1;
                r.val = data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
            end
            else
            begin
                r.val = data_t'(mag[DATA_WIDTH-1:0]);
            end
        end
        else
        begin
            if (mag > pos_lim + mag_t'(1))
            begin
                r.sat = 1'b1;
                r.val = data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});
            end
            else
            begin
                r.val = -data_t'(mag[DATA_WIDTH-1:0]);
            end
        end
        return r;
    endfunction

    function automatic clamp_t clamp_wide(input wide_t v);
        logic              neg;
        logic [DATA_WIDTH:0] m;
        neg = v[DATA_WIDTH];
        m   = neg ? (DATA_WIDTH+1)'(-v) : (DATA_WIDTH+1)'(v);
        return clamp_mag(neg, mag_t'(m));
    endfunction

endpackage

`default_nettype wire

>>> design/cau_req_if.sv
// request channel: operation and two complex operands
`default_nettype none

interface cau_req_if;
    import cau_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic signed [FIELD_W-1:0]  a_re;
    logic signed [FIELD_W-1:0]  a_im;
    logic signed [FIELD_W-1:0]  b_re;
    logic signed [FIELD_W-1:0]  b_im;

    modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

`default_nettype wire

>>> design/cau_rsp_if.sv
// response channel: complex result and flags
`default_nettype none

interface cau_rsp_if;
    import cau_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  res_re;
    logic signed [FIELD_W-1:0]  res_im;
    logic                       div_zero;
    logic                       saturated;

    modport source (output valid, res_re, res_im, div_zero, saturated, input ready);
    modport sink   (input valid, res_re, res_im, div_zero, saturated, output ready);
endinterface

`default_nettype wire

>>> design/cau_iter_stage.sv
// one pipeline stage of the restoring divider pair and the square root
`default_nettype none

module cau_iter_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire cau_pkg::iter_t stg_in,
    output cau_pkg::iter_t      stg_out
);
    import cau_pkg::*;

    iter_t stg_reg;
    iter_t stg_next;

    always_comb
    begin
        iter_t                t;
        mag_t                 rem2;
        logic [SQ_REM_W+1:0]  sr2;
        logic [SQ_REM_W+1:0]  trial;
        t = stg_in;
        for (int k = 0; k < STEPS_PER_STG; k++)
        begin
            // real quotient bit
            rem2     = {t.re_rem[PROD_W-2:0], t.re_low[DATA_WIDTH-1]};
            t.re_low = t.re_low << 1;
            if (rem2 >= t.dsr)
            begin
                t.re_rem = rem2 - t.dsr;
                t.re_q   = {t.re_q[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                t.re_rem = rem2;
                t.re_q   = {t.re_q[DATA_WIDTH-2:0], 1'b0};
            end
            // imaginary quotient bit
            rem2     = {t.im_rem[PROD_W-2:0], t.im_low[DATA_WIDTH-1]};
            t.im_low = t.im_low << 1;
            if (rem2 >= t.dsr)
            begin
                t.im_rem = rem2 - t.dsr;
                t.im_q   = {t.im_q[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                t.im_rem = rem2;
                t.im_q   = {t.im_q[DATA_WIDTH-2:0], 1'b0};
            end
            // square root digit, two radicand bits per step
            sr2    = {t.sq_rem, t.sq_s[PROD_W-1 -: 2]};
            t.sq_s = t.sq_s << 2;
            trial  = (SQ_REM_W+2)'({t.sq_root, 2'b01});
            if (sr2 >= trial)
            begin
                t.sq_rem  = SQ_REM_W'(sr2 - trial);
                t.sq_root = {t.sq_root[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                t.sq_rem  = SQ_REM_W'(sr2);
                t.sq_root = {t.sq_root[DATA_WIDTH-2:0], 1'b0};
            end
        end
        stg_next = t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_reg.v <= 1'b0;
        end
        else if (en)
        begin
            stg_reg <= stg_next;
        end
    end

    assign stg_out = stg_reg;

endmodule

`default_nettype wire

>>> design/complex_arithmetic_unit.sv
// Complex arithmetic unit, signed Q16.16: add, subtract, multiply, divide,
// modulus and conjugate, with saturation and a divide-by-zero flag. Fully
// pipelined: one transaction is accepted per cycle while the output is not
// stalled, and it passes through 21 register stages (input register,
// product stage, sum stage, prepare stage, 16 divide/square-root stages each
// resolving two quotient and root bits, output register). The pipeline moves
// as a whole; it halts only while the output register holds a result that
// the sink does not take.
`default_nettype none

module complex_arithmetic_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    cau_req_if.sink   req,
    cau_rsp_if.source rsp
);
    import cau_pkg::*;

    logic en;

    // input register
    logic              s1_v_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    data_t             s1_are_reg, s1_aim_reg, s1_bre_reg, s1_bim_reg;

    // product stage
    logic              s2_v_reg;
    logic [KIND_W-1:0] s2_kind_reg;
    prod_t             p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    data_t             s2_re_reg, s2_im_reg;
    logic              s2_sat_reg;
    prod_t             p0_next, p1_next, p2_next, p3_next, p4_next, p5_next;
    clamp_t            c_re, c_im;

    // sum stage
    logic              s3_v_reg;
    logic [KIND_W-1:0] s3_kind_reg;
    psum_t             s3_re_sum_reg, s3_im_sum_reg;
    mag_t              s3_dsr_reg;
    data_t             s3_re_reg, s3_im_reg;
    logic              s3_sat_reg;

    iter_t             prep_next;
    iter_t             chain [0:N_ITER_STG];
    iter_t             prep_reg;
    iter_t             lst;

    // output register
    logic              out_v_reg;
    data_t             res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic              dz_reg, sat_reg, dz_next, sat_next;

    assign en        = !out_v_reg || rsp.ready;
    assign req.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg    <= req.valid;
            s1_kind_reg <= req.kind;
            s1_are_reg  <= data_t'(req.a_re[DATA_WIDTH-1:0]);
            s1_aim_reg  <= data_t'(req.a_im[DATA_WIDTH-1:0]);
            s1_bre_reg  <= data_t'(req.b_re[DATA_WIDTH-1:0]);
            s1_bim_reg  <= data_t'(req.b_im[DATA_WIDTH-1:0]);
        end
    end

    always_comb
    begin
        data_t x4, x5;
        x4      = (s1_kind_reg == KIND_MOD) ? s1_are_reg : s1_bre_reg;
        x5      = (s1_kind_reg == KIND_MOD) ? s1_aim_reg : s1_bim_reg;
        p0_next = prod_t'(s1_are_reg) * prod_t'(s1_bre_reg);
        p1_next = prod_t'(s1_aim_reg) * prod_t'(s1_bim_reg);
        p2_next = prod_t'(s1_aim_reg) * prod_t'(s1_bre_reg);
        p3_next = prod_t'(s1_are_reg) * prod_t'(s1_bim_reg);
        p4_next = prod_t'(x4) * prod_t'(x4);
        p5_next = prod_t'(x5) * prod_t'(x5);
        c_re    = '0;
        c_im    = '0;
        case (s1_kind_reg)
            KIND_ADD:
            begin
                c_re = clamp_wide(wide_t'(s1_are_reg) + wide_t'(s1_bre_reg));
                c_im = clamp_wide(wide_t'(s1_aim_reg) + wide_t'(s1_bim_reg));
            end
            KIND_SUB:
            begin
                c_re = clamp_wide(wide_t'(s1_are_reg) - wide_t'(s1_bre_reg));
                c_im = clamp_wide(wide_t'(s1_aim_reg) - wide_t'(s1_bim_reg));
            end
            KIND_CONJ:
            begin
                c_re.val = s1_are_reg;
                c_im     = clamp_wide(-wide_t'(s1_aim_reg));
            end
            default:
            begin
                c_re = '0;
                c_im = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg    <= s1_v_reg;
            s2_kind_reg <= s1_kind_reg;
            p0_reg      <= p0_next;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            p3_reg      <= p3_next;
            p4_reg      <= p4_next;
            p5_reg      <= p5_next;
            s2_re_reg   <= c_re.val;
            s2_im_reg   <= c_im.val;
            s2_sat_reg  <= c_re.sat | c_im.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg    <= s2_v_reg;
            s3_kind_reg <= s2_kind_reg;
            if (s2_kind_reg == KIND_MUL)
            begin
                s3_re_sum_reg <= psum_t'(p0_reg) - psum_t'(p1_reg);
                s3_im_sum_reg <= psum_t'(p2_reg) + psum_t'(p3_reg);
            end
            else
            begin
                s3_re_sum_reg <= psum_t'(p0_reg) + psum_t'(p1_reg);
                s3_im_sum_reg <= psum_t'(p2_reg) - psum_t'(p3_reg);
            end
            s3_dsr_reg <= mag_t'(p4_reg) + mag_t'(p5_reg);
            s3_re_reg  <= s2_re_reg;
            s3_im_reg  <= s2_im_reg;
            s3_sat_reg <= s2_sat_reg;
        end
    end

    // sign-magnitude split, multiply clamp, divider and square-root setup
    always_comb
    begin
        mag_t   re_mag, im_mag;
        clamp_t m_re, m_im;
        prep_next.v    = s3_v_reg;
        prep_next.kind = s3_kind_reg;
        prep_next.re_neg = s3_re_sum_reg[PROD_W];
        prep_next.im_neg = s3_im_sum_reg[PROD_W];
        re_mag = s3_re_sum_reg[PROD_W] ? PROD_W'(-s3_re_sum_reg) : PROD_W'(s3_re_sum_reg);
        im_mag = s3_im_sum_reg[PROD_W] ? PROD_W'(-s3_im_sum_reg) : PROD_W'(s3_im_sum_reg);
        m_re   = clamp_mag(s3_re_sum_reg[PROD_W], re_mag >> FRAC_BITS);
        m_im   = clamp_mag(s3_im_sum_reg[PROD_W], im_mag >> FRAC_BITS);
        prep_next.dsr    = s3_dsr_reg;
        prep_next.re_rem = re_mag >> (DATA_WIDTH - FRAC_BITS);
        prep_next.im_rem = im_mag >> (DATA_WIDTH - FRAC_BITS);
        prep_next.re_ovf = (re_mag >> (DATA_WIDTH - FRAC_BITS)) >= s3_dsr_reg;
        prep_next.im_ovf = (im_mag >> (DATA_WIDTH - FRAC_BITS)) >= s3_dsr_reg;
        prep_next.re_low = re_mag[DATA_WIDTH-1:0] << FRAC_BITS;
        prep_next.im_low = im_mag[DATA_WIDTH-1:0] << FRAC_BITS;
        prep_next.re_q   = '0;
        prep_next.im_q   = '0;
        prep_next.sq_s    = s3_dsr_reg;
        prep_next.sq_rem  = '0;
        prep_next.sq_root = '0;
        prep_next.fin_dz  = 1'b0;
        case (s3_kind_reg)
            KIND_MUL:
            begin
                prep_next.fin_re  = m_re.val;
                prep_next.fin_im  = m_im.val;
                prep_next.fin_sat = m_re.sat | m_im.sat;
            end
            KIND_DIV:
            begin
                prep_next.fin_re  = '0;
                prep_next.fin_im  = '0;
                prep_next.fin_sat = 1'b0;
                prep_next.fin_dz  = (s3_dsr_reg == '0);
            end
            default:
            begin
                prep_next.fin_re  = s3_re_reg;
                prep_next.fin_im  = s3_im_reg;
                prep_next.fin_sat = s3_sat_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_reg.v <= 1'b0;
        end
        else if (en)
        begin
            prep_reg <= prep_next;
        end
    end

    assign chain[0] = prep_reg;

    for (genvar g = 0; g < N_ITER_STG; g++)
    begin : g_iter
        cau_iter_stage u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .stg_in  (chain[g]),
            .stg_out (chain[g+1])
        );
    end

    assign lst = chain[N_ITER_STG];

    always_comb
    begin
        clamp_t f_re, f_im;
        f_re.val = lst.fin_re;
        f_re.sat = lst.fin_sat;
        f_im.val = lst.fin_im;
        f_im.sat = 1'b0;
        dz_next  = lst.fin_dz;
        case (lst.kind)
            KIND_DIV:
            begin
                if (!lst.fin_dz)
                begin
                    f_re = clamp_mag(lst.re_neg, lst.re_ovf ? '1 : mag_t'(lst.re_q));
                    f_im = clamp_mag(lst.im_neg, lst.im_ovf ? '1 : mag_t'(lst.im_q));
                end
            end
            KIND_MOD:
            begin
                f_re     = clamp_mag(1'b0, mag_t'(lst.sq_root));
                f_im.val = '0;
            end
            default:
            begin
                f_im.sat = 1'b0;
            end
        endcase
        res_re_next = f_re.val;
        res_im_next = f_im.val;
        sat_next    = f_re.sat | f_im.sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg  <= lst.v;
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            dz_reg     <= dz_next;
            sat_reg    <= sat_next;
        end
    end

    assign rsp.valid     = out_v_reg;
    assign rsp.res_re    = FIELD_W'(res_re_reg);
    assign rsp.res_im    = FIELD_W'(res_im_reg);
    assign rsp.div_zero  = dz_reg;
    assign rsp.saturated = sat_reg;

endmodule

`default_nettype wire

>>> design/cau_checker.sv
// port-level checker for the complex arithmetic unit, bound to the top level
`default_nettype none

module cau_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] res_re,
    input wire logic [31:0] res_im,
    input wire logic        div_zero,
    input wire logic        saturated
);
`include "complex_arithmetic_unit_assert.svh"

    // a stalled result stays offered
    `CAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

    // the pipeline takes no transaction while the output is stalled
    `CAU_ASSERT_NOW(a_req_stall, rsp_valid && !rsp_ready, !req_ready)

    // divide by zero yields a zero, unsaturated result
    `CAU_ASSERT_NOW(a_dz_zero, rsp_valid && div_zero,
        res_re == 32'd0 && res_im == 32'd0 && !saturated)

    // the unit is always free to accept a request when no result is held
    `CAU_ASSERT_NOW(a_req_free, !rsp_valid, req_ready)

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .res_re    (rsp.res_re),
    .res_im    (rsp.res_im),
    .div_zero  (rsp.div_zero),
    .saturated (rsp.saturated)
);

`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench of the complex arithmetic unit with a built-in result predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        dz;
        logic        sat;
    } result_t;

    logic clk;
    logic rst_n;
    cau_req_if req ();
    cau_rsp_if rsp ();

    complex_arithmetic_unit DUT (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    result_t     pending_results[$];
    int          mismatch_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    // clamp sign-magnitude value to the 32-bit signed range
    function automatic logic [31:0] clamp_sm(input logic neg, input logic [63:0] mag,
                                             inout logic sat);
        if (!neg)
        begin
            if (mag > 64'h7fffffff)
            begin
                sat = 1'b1;
                return 32'h7fffffff;
            end
            return mag[31:0];
        end
        if (mag > 64'h80000000)
        begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return -mag[31:0];
    endfunction

    function automatic logic [31:0] clamp_signed(input logic signed [63:0] v, inout logic sat);
        return clamp_sm(v < 0, v < 0 ? -v : v, sat);
    endfunction

    // two's complement sum whose true value lies in [-(2^63-1), 2^63]
    function automatic logic [31:0] clamp_prod(input logic [63:0] v, input bit shift,
                                               input logic [63:0] d, inout logic sat);
        logic        neg;
        logic [63:0] mag;
        logic [127:0] q;
        neg = v[63] && v != 64'h8000000000000000;
        mag = neg ? -v : v;
        if (shift)
            return clamp_sm(neg, mag >> 16, sat);
        q = {mag, 16'b0} / d;
        if (q[127:64] != 0)
            return clamp_sm(neg, 64'hffffffffffffffff, sat);
        return clamp_sm(neg, q[63:0], sat);
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h4000000000000000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic result_t predict_complex(input logic [2:0] kind,
                                                input logic signed [31:0] ar, ai, br, bi);
        result_t     o;
        logic        sat;
        logic signed [63:0] xr, xi, yr, yi;
        logic [63:0] d;
        sat = 1'b0;
        o = '0;
        xr = ar; xi = ai; yr = br; yi = bi;
        case (kind)
            KIND_ADD:
            begin
                o.re = clamp_signed(xr + yr, sat);
                o.im = clamp_signed(xi + yi, sat);
            end
            KIND_SUB:
            begin
                o.re = clamp_signed(xr - yr, sat);
                o.im = clamp_signed(xi - yi, sat);
            end
            KIND_MUL:
            begin
                o.re = clamp_prod(xr * yr - xi * yi, 1'b1, 64'd1, sat);
                o.im = clamp_prod(xi * yr + yi * xr, 1'b1, 64'd1, sat);
            end
            KIND_DIV:
            begin
                d = yr * yr + yi * yi;
                if (d == 0)
                    o.dz = 1'b1;
                else
                begin
                    o.re = clamp_prod(xr * yr + xi * yi, 1'b0, d, sat);
                    o.im = clamp_prod(xi * yr - xr * yi, 1'b0, d, sat);
                end
            end
            KIND_MOD:
                o.re = clamp_sm(1'b0, root_floor(xr * xr + xi * xi), sat);
            KIND_CONJ:
            begin
                o.re = ar;
                o.im = clamp_signed(-xi, sat);
            end
            default: ;
        endcase
        o.sat = sat;
        return o;
    endfunction

    // valid stays high between back-to-back transactions and drops only while idling
    task automatic send_item(input logic [2:0] kind, input logic [31:0] ar, ai, br, bi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        pending_results.push_back(predict_complex(kind, ar, ai, br, bi));
        req.valid <= 1'b1;
        req.kind  <= kind;
        req.a_re  <= ar;
        req.a_im  <= ai;
        req.b_re  <= br;
        req.b_im  <= bi;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // receiver side: random stalls and the comparison against the oldest expectation
    initial
    begin
        result_t want;
        result_t got;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.res_re, rsp.res_im, rsp.div_zero, rsp.saturated};
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected transaction %h", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp %h %h %b %b, got %h %h %b %b",
                                     want.re, want.im, want.dz, want.sat,
                                     got.re, got.im, got.dz, got.sat);
                    end
                end
            end
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h0;
            3: return $urandom_range(131072) - 65536;
            4: return $urandom_range(16'hffff) - 32768;
            5: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] e[4];
        e = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff};
        for (int k = KIND_ADD; k <= 7; k++)
            for (int j = 0; j < 3; j++)
                send_item(3'(k), e[j], e[(j + 1) % 4], e[(j + 2) % 4], e[(j + 3) % 4]);
        send_item(KIND_DIV, 32'h00010000, 32'h0, 32'h0, 32'h0);
        send_item(KIND_CONJ, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0);
        send_item(KIND_MOD, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
        send_item(KIND_DIV, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'h0);
    endtask

    task automatic test_random(input int n, input int unsigned idle, input int unsigned stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n)
            send_item(3'(($urandom_range(15) == 0) ? $urandom_range(7) : $urandom_range(5)),
                      pick_operand(), pick_operand(), pick_operand(), pick_operand());
    endtask

    initial
    begin
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.kind  = '0;
        req.a_re  = '0;
        req.a_im  = '0;
        req.b_re  = '0;
        req.b_im  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(330, 0, 0);
        test_random(320, 63, 0);
        test_random(320, 0, 63);
        test_random(330, 36, 36);
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
